// ===== src/bilinear_image_scaler_defines.svh =====
// Assertion macros for the bilinear image scaler.
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH
`ifndef SYNTH
`define BIS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("label failed");
`define BIS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("label failed");
`else
`define BIS_ASSERT_IMP(label, clk, rst, a, c)
`define BIS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== src/bis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and register indexes of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ = 1'b1;
  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MAP  = 7'b0000010,
    ST_RD   = 7'b0000100,
    ST_COL  = 7'b0001000,
    ST_ROWA = 7'b0010000,
    ST_ROWB = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;
endpackage

// ===== src/bilinear_image_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Source frame store with bilinear read-back at scaled coordinates.
// ----------------------------------------------------------------------------
// Use:
//   s_axis_* carries requests. tuser = req_type (0 write pixel, 1 read).
//   tdata holds row, col, in_ch0, in_ch1, in_ch2 from the low bit up.
//   A write stores one pixel and gives no result. A read gives one transfer
//   on m_axis_*: tdata = {out_ch2, out_ch1, out_ch0}, tuser = outside.
//   cfg_we/cfg_idx/cfg_data write the size, step and channel registers.
// Sequence:
//   A write is stored at the edge that accepts it. A read is mapped to
//   source coordinates, walks the single-port frame store four times (one
//   neighbor per cycle) and then blends in two multiply steps before the
//   result register is loaded; an outside point is answered from the first
//   read state. No new request is taken until the read is done.
//   The single store port makes the neighbor reads go one at a time.
// Reset clears the registers to full 256x256 size, unit steps, 3 channels;
//   the frame store is not cleared. The result waits in the output register
//   while m_axis_tready is low; the next request is taken once it has left.
module bilinear_image_scaler #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [47:0] s_axis_tdata, // row[11:0], col[23:12], ch0, ch1, ch2
  input  logic s_axis_tuser,        // req_type
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [23:0] m_axis_tdata, // out_ch0, out_ch1, out_ch2
  output logic m_axis_tuser,        // outside
  input  logic cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bis_pkg::*;
`include "bilinear_image_scaler_defines.svh"

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned PW = 12 + 24;       // coordinate product width
  localparam int unsigned S1 = FRAC_BITS + 1;  // weight width
  localparam int unsigned TW = 8 + S1;         // row blend width
  localparam int unsigned BW = TW + S1;        // final blend width

  // Configuration registers
  logic [8:0] source_rows, source_cols;
  logic [23:0] row_step, col_step;
  logic [1:0] channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rows <= 9'd256;
      source_cols <= 9'd256;
      row_step <= 24'd65536;
      col_step <= 24'd65536;
      channel_count <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SOURCE_ROWS:   source_rows <= cfg_data[8:0];
        REG_SOURCE_COLS:   source_cols <= cfg_data[8:0];
        REG_ROW_STEP:      row_step <= cfg_data;
        REG_COL_STEP:      col_step <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes: 0 reads as 1, above the store size reads as the store size
  logic [12:0] srows, scols;
  always_comb begin
    srows = (source_rows == 9'd0) ? 13'd1 :
            ({4'd0, source_rows} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : {4'd0, source_rows};
    scols = (source_cols == 9'd0) ? 13'd1 :
            ({4'd0, source_cols} > 13'(MAX_COLS)) ? 13'(MAX_COLS) : {4'd0, source_cols};
  end

  // Frame store: one port, read data registered
  logic [23:0] mem [DEPTH];
  logic mem_we;
  logic [RW+CW-1:0] mem_addr;
  logic [23:0] mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  state_t state;
  logic [1:0] nb;                 // neighbor being read
  logic [PW-1:0] rfix, cfix;
  logic [11:0] req_row, req_col;
  logic [23:0] px [4];
  logic [TW-1:0] top [3], bot [3];
  logic [BW-1:0] acc [3];
  logic [FRAC_BITS-1:0] fr, fc;
  logic [RW-1:0] ri, ri2;
  logic [CW-1:0] ci, ci2;
  logic out_v, out_o;
  logic [23:0] out_d;

  assign fr = rfix[FRAC_BITS-1:0];
  assign fc = cfix[FRAC_BITS-1:0];
  assign ri = RW'(rfix >> FRAC_BITS);
  assign ci = CW'(cfix >> FRAC_BITS);
  assign ri2 = (fr != '0) ? ri + 1'b1 : ri;
  assign ci2 = (fc != '0) ? ci + 1'b1 : ci;

  logic in_acc, wr_ok;
  logic outside_hit;
  assign s_axis_tready = (state == ST_IDLE) && !out_v;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign wr_ok = (s_axis_tuser == REQ_WRITE) && ({20'd0, s_axis_tdata[11:0]} < 32'(MAX_ROWS))
                 && ({20'd0, s_axis_tdata[23:12]} < 32'(MAX_COLS));
  assign outside_hit = (rfix > (PW'(srows - 13'd1) << FRAC_BITS)) ||
                       (cfix > (PW'(scols - 13'd1) << FRAC_BITS));

  // Store address mux
  always_comb begin
    mem_we = in_acc && wr_ok;
    mem_wdata = s_axis_tdata[47:24];
    mem_addr = {s_axis_tdata[RW-1:0], s_axis_tdata[12+CW-1:12]};
    if (state == ST_RD) begin
      case (nb)
        2'd0: mem_addr = {ri, ci};
        2'd1: mem_addr = {ri, ci2};
        2'd2: mem_addr = {ri2, ci};
        default: mem_addr = {ri2, ci2};
      endcase
    end
  end

  logic [1:0] rd_pend;     // slot of the read data pending capture
  logic rd_live;
  logic [S1-1:0] one_w;
  assign one_w = S1'(1) << FRAC_BITS;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_v <= 1'b0;
      nb <= '0;
      rd_live <= 1'b0;
    end else begin
      if (out_v && m_axis_tready) out_v <= 1'b0;
      rd_live <= (state == ST_RD);
      rd_pend <= nb;
      if (rd_live) px[rd_pend] <= mem_rdata;
      case (state)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser == REQ_READ) begin
            req_row <= s_axis_tdata[11:0];
            req_col <= s_axis_tdata[23:12];
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          rfix <= PW'(req_row) * PW'(row_step);
          cfix <= PW'(req_col) * PW'(col_step);
          nb <= '0;
          state <= ST_RD;
        end
        ST_RD: begin
          if (nb == 2'd0 && outside_hit) begin
            out_d <= '0;
            out_o <= 1'b1;
            out_v <= 1'b1;
            state <= ST_IDLE;
          end else begin
            nb <= nb + 1'b1;
            if (nb == 2'd3) state <= ST_COL;
          end
        end
        ST_COL: begin
          // last read lands this cycle
          state <= ST_ROWA;
        end
        ST_ROWA: begin
          for (int k = 0; k < 3; k++) begin
            top[k] <= TW'(px[0][8*k +: 8]) * TW'(one_w - S1'(fc)) +
                      TW'(px[1][8*k +: 8]) * TW'(fc);
            bot[k] <= TW'(px[2][8*k +: 8]) * TW'(one_w - S1'(fc)) +
                      TW'(px[3][8*k +: 8]) * TW'(fc);
          end
          state <= ST_ROWB;
        end
        ST_ROWB: begin
          for (int k = 0; k < 3; k++) begin
            acc[k] <= BW'(top[k]) * BW'(one_w - S1'(fr)) + BW'(bot[k]) * BW'(fr);
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          for (int k = 0; k < 3; k++) begin
            out_d[8*k +: 8] <= (2'(k) < channel_count) ? acc[k][2*FRAC_BITS +: 8] : 8'd0;
          end
          out_o <= 1'b0;
          out_v <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata = out_d;
  assign m_axis_tuser = out_o;

  `BIS_ASSERT_IMP(a_ready_idle, clk, rst, s_axis_tready, state == ST_IDLE)
  `BIS_ASSERT_NEXT(a_out_hold, clk, rst, out_v && !m_axis_tready, out_v && $stable(out_d))
  `BIS_ASSERT_IMP(a_busy_no_out, clk, rst, state != ST_IDLE, !out_v)
  `BIS_ASSERT_IMP(a_outside_zero, clk, rst, out_v && out_o, out_d == 24'd0)
endmodule

// ===== test/scaler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaler_checker
// Watches the request, result and register ports of the scaler, keeps its
// own copy of the frame store and registers, works out each interpolated
// pixel when a read is accepted, and compares it with the result transfers.
// ----------------------------------------------------------------------------
module scaler_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [47:0] s_axis_tdata, // row, col, ch0, ch1, ch2
  input  logic s_axis_tuser,        // req_type
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [23:0] m_axis_tdata, // out_ch0, out_ch1, out_ch2
  input  logic m_axis_tuser,        // outside
  input  logic cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data,
  output int failures,
  output int pending
);
  import bis_pkg::*;

  localparam int unsigned STORE_ROWS = 256;
  localparam int unsigned STORE_COLS = 256;
  localparam int unsigned FRAC = 16;

  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       outside;
  } pixel_t;

  logic [23:0] pixels [0:STORE_ROWS*STORE_COLS-1];
  logic [8:0]  rows_reg, cols_reg;
  logic [23:0] rstep_reg, cstep_reg;
  logic [1:0]  chans_reg;
  pixel_t      expected_pixels [$];

  initial begin
    failures = 0;
    for (int i = 0; i < STORE_ROWS*STORE_COLS; i++) pixels[i] = '0;
  end

  assign pending = expected_pixels.size();

  function automatic longint unsigned clamp_dim(logic [8:0] v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // Bilinear blend of the four neighbors at the mapped source point
  function automatic pixel_t blend_pixel(logic [11:0] r, logic [11:0] c);
    longint unsigned one, nr, nc, rfix, cfix, ri, ci, fr, fc, ri2, ci2, top, bot, v;
    logic [23:0] p00, p01, p10, p11;
    pixel_t res;
    one = 64'd1 << FRAC;
    nr = clamp_dim(rows_reg, STORE_ROWS);
    nc = clamp_dim(cols_reg, STORE_COLS);
    rfix = longint'(r) * longint'(rstep_reg);
    cfix = longint'(c) * longint'(cstep_reg);
    res = '0;
    if (rfix > ((nr - 1) << FRAC) || cfix > ((nc - 1) << FRAC)) begin
      res.outside = 1'b1;
      return res;
    end
    ri = rfix >> FRAC;
    ci = cfix >> FRAC;
    fr = rfix & (one - 1);
    fc = cfix & (one - 1);
    ri2 = (fr != 0) ? ri + 1 : ri;
    ci2 = (fc != 0) ? ci + 1 : ci;
    p00 = pixels[ri*STORE_COLS + ci];
    p01 = pixels[ri*STORE_COLS + ci2];
    p10 = pixels[ri2*STORE_COLS + ci];
    p11 = pixels[ri2*STORE_COLS + ci2];
    for (int k = 0; k < 3; k++) begin
      v = 0;
      if (k < chans_reg) begin
        top = longint'(p00[8*k +: 8]) * (one - fc) + longint'(p01[8*k +: 8]) * fc;
        bot = longint'(p10[8*k +: 8]) * (one - fc) + longint'(p11[8*k +: 8]) * fc;
        v = (top * (one - fr) + bot * fr) >> (2*FRAC);
      end
      case (k)
        0: res.ch0 = v[7:0];
        1: res.ch1 = v[7:0];
        default: res.ch2 = v[7:0];
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_t want, got;
    logic [11:0] r, c;
    if (rst) begin
      rows_reg <= 9'd256;
      cols_reg <= 9'd256;
      rstep_reg <= 24'd65536;
      cstep_reg <= 24'd65536;
      chans_reg <= 2'd3;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_SOURCE_ROWS:   rows_reg <= cfg_data[8:0];
          REG_SOURCE_COLS:   cols_reg <= cfg_data[8:0];
          REG_ROW_STEP:      rstep_reg <= cfg_data;
          REG_COL_STEP:      cstep_reg <= cfg_data;
          REG_CHANNEL_COUNT: chans_reg <= cfg_data[1:0];
          default: ;
        endcase
      end
      // request transfers
      if (s_axis_tvalid && s_axis_tready) begin
        r = s_axis_tdata[11:0];
        c = s_axis_tdata[23:12];
        if (s_axis_tuser == REQ_WRITE) begin
          if (r < STORE_ROWS && c < STORE_COLS)
            pixels[r*STORE_COLS + c] = s_axis_tdata[47:24];
        end else begin
          expected_pixels.push_back(blend_pixel(r, c));
        end
      end
      // result transfers
      if (m_axis_tvalid && m_axis_tready) begin
        got.ch0 = m_axis_tdata[7:0];
        got.ch1 = m_axis_tdata[15:8];
        got.ch2 = m_axis_tdata[23:16];
        got.outside = m_axis_tuser;
        if (expected_pixels.size() == 0) begin
          $error("result with no read pending: data %h outside %0d",
                 m_axis_tdata, m_axis_tuser);
          failures++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.ch0 !== want.ch0) begin
            $error("out_ch0 expected %0d actual %0d", want.ch0, got.ch0); failures++;
          end
          if (got.ch1 !== want.ch1) begin
            $error("out_ch1 expected %0d actual %0d", want.ch1, got.ch1); failures++;
          end
          if (got.ch2 !== want.ch2) begin
            $error("out_ch2 expected %0d actual %0d", want.ch2, got.ch2); failures++;
          end
          if (got.outside !== want.outside) begin
            $error("outside expected %0d actual %0d", want.outside, got.outside);
            failures++;
          end
        end
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel writes and interpolated reads into the scaler across several
// frame sizes, steps and channel counts, with random stalls on both sides;
// the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
  import bis_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [47:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [23:0] m_axis_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int failures, pending;
  int cycles, n_reads, n_writes;
  bit calm;

  // current frame setup, as the block will see it
  int eff_rows, eff_cols;
  logic [23:0] cur_rstep, cur_cstep;

  bilinear_image_scaler uut (.*);
  scaler_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send(logic kind, logic [11:0] r, logic [11:0] c, logic [23:0] pix);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = {pix, c, r};
    do @(posedge clk); while (!s_axis_tready);
    if (kind == REQ_READ) n_reads++; else n_writes++;
  endtask

  // let the block drain before touching its registers
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int clamp_dim(int v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : v;
  endfunction

  task automatic setup_frame(int nr, int nc, logic [23:0] rs, logic [23:0] cs, int ch);
    settle();
    reg_write(REG_SOURCE_ROWS, CFG_DATA_W'(nr));
    reg_write(REG_SOURCE_COLS, CFG_DATA_W'(nc));
    reg_write(REG_ROW_STEP, rs);
    reg_write(REG_COL_STEP, cs);
    reg_write(REG_CHANNEL_COUNT, CFG_DATA_W'(ch));
    eff_rows = clamp_dim(nr);
    eff_cols = clamp_dim(nc);
    cur_rstep = rs;
    cur_cstep = cs;
    // fill the whole configured frame so no read lands on an unwritten pixel
    for (int r = 0; r < eff_rows; r++)
      for (int c = 0; c < eff_cols; c++)
        send(REQ_WRITE, 12'(r), 12'(c), 24'($urandom));
  endtask

  // destination coordinate that maps inside the frame
  function automatic logic [11:0] inside_coord(int n, logic [23:0] step);
    longint unsigned top;
    if (step == 0) return 12'($urandom_range(0, 4095));
    top = (longint'(n - 1) << 16) / step;
    if (top > 4095) top = 4095;
    return 12'($urandom_range(0, int'(top)));
  endfunction

  task automatic random_traffic(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        send(REQ_READ, inside_coord(eff_rows, cur_rstep),
             inside_coord(eff_cols, cur_cstep), 24'($urandom));
      else if (pick < 70)
        send(REQ_READ, 12'($urandom), 12'($urandom), 24'($urandom));
      else if (pick < 95)
        send(REQ_WRITE, 12'($urandom_range(0, eff_rows - 1)),
             12'($urandom_range(0, eff_cols - 1)), 24'($urandom));
      else
        send(REQ_WRITE, 12'($urandom), 12'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = REQ_WRITE;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_SOURCE_ROWS;
    cfg_data = '0;
    calm = 1'b0;
    cycles = 0;
    n_reads = 0;
    n_writes = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 4x4 checkerboard of full-scale pixels, half steps
    settle();
    reg_write(REG_SOURCE_ROWS, 24'd4);
    reg_write(REG_SOURCE_COLS, 24'd4);
    reg_write(REG_ROW_STEP, 24'h008000);
    reg_write(REG_COL_STEP, 24'h008000);
    eff_rows = 4; eff_cols = 4; cur_rstep = 24'h008000; cur_cstep = 24'h008000;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send(REQ_WRITE, 12'(r), 12'(c), ((r + c) % 2) ? 24'hFFFFFF : 24'h000000);
    send(REQ_WRITE, 12'hFFF, 12'hFFF, 24'hFFFFFF);   // beyond the store, dropped
    send(REQ_READ, 12'd0, 12'd0, 24'd0);               // corner, zero fractions
    send(REQ_READ, 12'd6, 12'd6, 24'd0);               // last pixel exactly
    send(REQ_READ, 12'd1, 12'd1, 24'd0);               // half way both ways
    send(REQ_READ, 12'd7, 12'd0, 24'd0);               // row past the edge
    send(REQ_READ, 12'd0, 12'd7, 24'd0);               // column past the edge
    send(REQ_READ, 12'hFFF, 12'hFFF, 24'hFFFFFF);      // far outside
    settle();
    reg_write(REG_CHANNEL_COUNT, 24'd1);               // only channel 0 in use
    reg_write(CFG_IDX_W'(REG_CHANNEL_COUNT + 1), 24'hFFFFFF); // unknown index, ignored
    send(REQ_READ, 12'd1, 12'd2, 24'd0);
    send(REQ_READ, 12'd3, 12'd3, 24'd0);

    // register extremes, then random setups with small frames
    setup_frame(0, 0, 24'd0, 24'd0, 0);
    random_traffic(40);
    setup_frame(511, 1, 24'hFFFFFF, 24'd1, 3);
    random_traffic(40);
    setup_frame(1, 256, 24'd65536, 24'h00C000, 2);
    random_traffic(40);
    setup_frame(256, 1, 24'h000100, 24'hFFFFFF, 3);
    random_traffic(40);
    for (int p = 0; p < 10; p++) begin
      setup_frame($urandom_range(1, 9), $urandom_range(1, 9),
                  24'($urandom_range(0, 24'h030000)), 24'($urandom_range(0, 24'h030000)),
                  $urandom_range(0, 3));
      if (p == 9) calm = 1'b1;
      random_traffic(p == 9 ? 130 : 30);
    end

    settle();
    $display("covered %0d pixel writes and %0d scaled reads over 15 frame setups",
             n_writes, n_reads);
    $display("sizes 0 to 511, steps 0 to full scale, channel counts 0 to 3");
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
